// ----- src/sba_pkg.sv -----
// ---------------------------------------------------------------------------
// sba_pkg
// Types, constants and the size class table of the slab bitmap allocator.
// ---------------------------------------------------------------------------
package sba_pkg;

    localparam int PAGE_BYTES         = 4096;
    localparam int PAGE_SHIFT         = 12;
    localparam int PAGE_COUNT         = 64;
    localparam int PAGE_W             = 6;
    localparam int LINK_W             = 7;
    localparam int MAX_CLASSES        = 15;
    localparam int ALIGN_BYTES        = 16;
    localparam int BASE_CLASS_BYTES   = 16;
    localparam int HEADER_FIXED_BYTES = 32;
    localparam int WORDS_PER_PAGE     = ((PAGE_BYTES / BASE_CLASS_BYTES) + 31) / 32;
    localparam int WORD_W             = 3;
    localparam int SLOT_AW            = PAGE_W + WORD_W;
    localparam int SLOT_DEPTH         = PAGE_COUNT * WORDS_PER_PAGE;
    localparam int IDX_W              = WORD_W + 5;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(PAGE_COUNT);
    localparam logic [3:0]        UNOWNED   = 4'd15;
    localparam logic              CMD_ALLOC = 1'b0;
    localparam logic              CMD_FREE  = 1'b1;
    localparam logic              FLD_NEXT  = 1'b0;
    localparam logic              FLD_PREV  = 1'b1;
    localparam logic [1:0]        REG_POOL  = 2'd0;
    localparam logic [1:0]        REG_BASE  = 2'd1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_PAGE   = 2'd2,
        ST_BAD_FREE  = 2'd3
    } status_t;

    typedef struct packed {
        logic        command;
        logic [12:0] request_size;
        logic [31:0] free_address;
    } req_t;

    typedef struct packed {
        logic [31:0] slot_address;
        status_t     status;
        logic [3:0]  size_class;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_DONE  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2
    } op_t;

    // One classified request, handed from the front end to the back end.
    typedef struct packed {
        op_t               op;
        status_t           status;
        logic [3:0]        cls;
        logic [PAGE_W-1:0] page;
        logic [11:0]       rel;
    } job_t;

    typedef struct packed {
        logic [3:0]        cls;
        logic [7:0]        count;
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
    } meta_t;

    localparam meta_t META_RESET = '{cls: UNOWNED, count: 8'd0,
                                     next: NULL_LINK, prev: NULL_LINK};

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_META_RD, S_META_LD, S_SCAN_RD, S_SCAN_CHK,
        S_ALLOC_CNT, S_DIV, S_FREE_RD, S_FREE_CHK, S_LINK, S_FREE_CNT,
        S_UNLINK, S_UNLINK2, S_UNLINK3, S_RMW_RD, S_RMW_WR, S_META_WR,
        S_MUL, S_ADDR, S_DONE
    } state_t;

    typedef struct packed {
        logic [12:0] limit;
        logic [8:0]  elems;
        logic [11:0] hdr;
        logic [3:0]  nwords;
        logic        valid;
    } class_info_t;

    typedef class_info_t [15:0] class_tab_t;

    function automatic int hdr_bytes(int n);
        return ((HEADER_FIXED_BYTES + 4 * ((n + 31) / 32) + ALIGN_BYTES - 1)
                / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    function automatic class_tab_t build_classes();
        class_tab_t t;
        int lim;
        int prev;
        int cap;
        int e;
        bit stop;
        t    = '0;
        prev = 0;
        lim  = 0;
        stop = 1'b0;
        cap  = PAGE_BYTES - hdr_bytes(1);
        for (int i = 0; i < MAX_CLASSES; i++) begin
            if (!stop) begin
                if (i == 0) begin
                    lim = BASE_CLASS_BYTES;
                end else begin
                    lim = (((3 * prev) / 2 + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
                    if (lim > cap) begin
                        lim = cap;
                        if (lim == prev) stop = 1'b1;
                    end
                end
                if (!stop) begin
                    e = 0;
                    while ((e + 1) * lim <= cap) e++;
                    while (e > 0 && e * lim + hdr_bytes(e) > PAGE_BYTES) e--;
                    if (e > WORDS_PER_PAGE * 32) e = WORDS_PER_PAGE * 32;
                    if (e < 1) begin
                        stop = 1'b1;
                    end else begin
                        t[i].limit  = 13'(lim);
                        t[i].elems  = 9'(e);
                        t[i].hdr    = 12'(hdr_bytes(e));
                        t[i].nwords = 4'((e + 31) / 32);
                        t[i].valid  = 1'b1;
                        prev        = lim;
                    end
                end
            end
        end
        return t;
    endfunction

    function automatic int count_classes();
        class_tab_t t;
        int n;
        t = build_classes();
        n = 0;
        for (int i = 0; i < 16; i++) begin
            if (t[i].valid) n++;
        end
        return n;
    endfunction

    localparam class_tab_t CLASS_TAB   = build_classes();
    localparam int         CLASS_COUNT = count_classes();

endpackage

// ----- src/sba_ram.sv -----
// ---------------------------------------------------------------------------
// sba_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module sba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- src/sba_front.sv -----
// ---------------------------------------------------------------------------
// sba_front
// Accepts requests, picks the size class or decodes the freed address, and
// queues the classified job for the back end in a two-entry queue.
// ---------------------------------------------------------------------------
module sba_front import sba_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  req_t        s_data,
    input  logic [6:0]  pool_pages,
    input  logic [31:0] base_address,
    input  logic        init_done,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job
);
    job_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    job_t       new_job;
    logic       push, pop;
    logic [6:0] active;
    logic [31:0] off;
    logic [3:0] cls_sel;
    logic       too_large;

    assign active = (pool_pages > 7'(PAGE_COUNT)) ? 7'(PAGE_COUNT) : pool_pages;
    assign off    = s_data.free_address - base_address;

    always_comb begin
        cls_sel = 4'(CLASS_COUNT - 1);
        for (int i = CLASS_COUNT - 2; i >= 0; i--) begin
            if (CLASS_TAB[i].limit >= s_data.request_size) cls_sel = 4'(i);
        end
        too_large = s_data.request_size > CLASS_TAB[CLASS_COUNT - 1].limit;
    end

    always_comb begin
        new_job        = '0;
        new_job.op     = OP_DONE;
        new_job.status = ST_OK;
        if (s_data.command == CMD_ALLOC) begin
            if (too_large) begin
                new_job.status = ST_TOO_LARGE;
            end else begin
                new_job.op  = OP_ALLOC;
                new_job.cls = cls_sel;
            end
        end else if (s_data.free_address != 32'd0) begin
            if (s_data.free_address < base_address) begin
                new_job.status = ST_BAD_FREE;
            end else if (off[31:PAGE_SHIFT] >= 20'(active)) begin
                new_job.status = ST_BAD_FREE;
            end else begin
                new_job.op   = OP_FREE;
                new_job.page = off[PAGE_SHIFT+PAGE_W-1:PAGE_SHIFT];
                new_job.rel  = off[PAGE_SHIFT-1:0];
            end
        end
    end

    assign s_ready   = init_done && (cnt_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop       = job_valid && job_ready;
    assign job       = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            q_reg[wr_ptr_reg] <= new_job;
        end
    end
endmodule

// ----- src/sba_back.sv -----
// ---------------------------------------------------------------------------
// sba_back
// Sequencer that carries out allocate and free jobs on the page metadata,
// the slot bitmaps and the class lists, and holds the result register.
// ---------------------------------------------------------------------------
module sba_back import sba_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [6:0]  pool_pages,
    input  logic [31:0] base_address,
    output logic        init_done,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job,
    output logic        m_valid,
    input  logic        m_ready,
    output rsp_t        m_data
);
    state_t            state_reg, state_next;
    state_t            ret_reg, ret_next;
    op_t               op_reg, op_next;
    status_t           status_reg, status_next;
    logic [3:0]        cls_reg, cls_next;
    logic [PAGE_W-1:0] p_reg, p_next;
    logic [11:0]       rel_reg, rel_next;
    meta_t             pm_reg, pm_next;
    logic [WORD_W-1:0] w_reg, w_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [PAGE_W-1:0] x_reg, x_next;
    logic              xf_reg, xf_next;
    logic [LINK_W-1:0] xv_reg, xv_next;
    logic              release_reg, release_next;
    logic [11:0]       dvd_reg, dvd_next;
    logic [12:0]       rem_reg, rem_next;
    logic [11:0]       quo_reg, quo_next;
    logic [3:0]        dcnt_reg, dcnt_next;
    logic [SLOT_AW-1:0] clr_reg, clr_next;
    logic [19:0]       prod_reg, prod_next;
    logic [31:0]       part_reg, part_next;
    logic [31:0]       addr_reg, addr_next;
    logic [LINK_W-1:0] head_reg [MAX_CLASSES];
    logic [LINK_W-1:0] head_next [MAX_CLASSES];
    logic [PAGE_COUNT-1:0] owned_reg, owned_next;
    logic [PAGE_COUNT-1:0] valid_reg, valid_next;
    logic              rvalid_reg;
    logic              m_valid_reg, m_valid_next;
    rsp_t              m_data_reg, m_data_next;

    logic              meta_we;
    logic [PAGE_W-1:0] meta_waddr, meta_raddr;
    meta_t             meta_wdata, meta_rdata;
    logic              slot_we;
    logic [SLOT_AW-1:0] slot_waddr, slot_raddr;
    logic [31:0]       slot_wdata, slot_rdata;

    class_info_t       ci;
    meta_t             rd_meta;
    meta_t             mod_meta;
    logic [6:0]        active;
    logic [PAGE_COUNT-1:0] free_vec;
    logic [PAGE_W-1:0] free_page;
    logic              free_any;
    logic [4:0]        zpos;
    logic [12:0]       r2;

    sba_ram #(.WIDTH($bits(meta_t)), .DEPTH(PAGE_COUNT)) u_meta_ram (
        .aclk(aclk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
        .raddr(meta_raddr), .rdata(meta_rdata)
    );

    sba_ram #(.WIDTH(32), .DEPTH(SLOT_DEPTH)) u_slot_ram (
        .aclk(aclk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .raddr(slot_raddr), .rdata(slot_rdata)
    );

    assign ci        = CLASS_TAB[cls_reg];
    assign rd_meta   = rvalid_reg ? meta_rdata : META_RESET;
    assign active    = (pool_pages > 7'(PAGE_COUNT)) ? 7'(PAGE_COUNT) : pool_pages;
    assign init_done = (state_reg != S_CLEAR);
    assign job_ready = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign r2        = {rem_reg[11:0], dvd_reg[11]};

    always_comb begin
        free_any  = 1'b0;
        free_page = '0;
        for (int i = 0; i < PAGE_COUNT; i++) begin
            free_vec[i] = !owned_reg[i] && (7'(i) < active);
        end
        for (int i = PAGE_COUNT - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                free_any  = 1'b1;
                free_page = PAGE_W'(i);
            end
        end
        zpos = '0;
        for (int b = 31; b >= 0; b--) begin
            if (!slot_rdata[b]) zpos = 5'(b);
        end
        mod_meta = rd_meta;
        if (xf_reg == FLD_NEXT) mod_meta.next = xv_reg;
        else mod_meta.prev = xv_reg;
    end

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        op_next      = op_reg;
        status_next  = status_reg;
        cls_next     = cls_reg;
        p_next       = p_reg;
        rel_next     = rel_reg;
        pm_next      = pm_reg;
        w_next       = w_reg;
        idx_next     = idx_reg;
        x_next       = x_reg;
        xf_next      = xf_reg;
        xv_next      = xv_reg;
        release_next = release_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dcnt_next    = dcnt_reg;
        clr_next     = clr_reg;
        prod_next    = prod_reg;
        part_next    = part_reg;
        addr_next    = addr_reg;
        head_next    = head_reg;
        owned_next   = owned_reg;
        valid_next   = valid_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        meta_we      = 1'b0;
        meta_waddr   = p_reg;
        meta_wdata   = pm_reg;
        meta_raddr   = p_reg;
        slot_we      = 1'b0;
        slot_waddr   = {p_reg, w_reg};
        slot_wdata   = slot_rdata;
        slot_raddr   = {p_reg, w_reg};

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                slot_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == SLOT_AW'(SLOT_DEPTH - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (job_valid) begin
                    op_next      = job.op;
                    status_next  = job.status;
                    cls_next     = job.cls;
                    rel_next     = job.rel;
                    addr_next    = '0;
                    release_next = 1'b0;
                    unique case (job.op)
                        OP_ALLOC: begin
                            if (head_reg[job.cls] == NULL_LINK) begin
                                if (!free_any) begin
                                    status_next = ST_NO_PAGE;
                                    state_next  = S_DONE;
                                end else begin
                                    // Refill: the new page is the only one on its list.
                                    p_next                = free_page;
                                    pm_next               = META_RESET;
                                    pm_next.cls           = job.cls;
                                    head_next[job.cls]    = {1'b0, free_page};
                                    owned_next[free_page] = 1'b1;
                                    w_next                = '0;
                                    state_next            = S_SCAN_RD;
                                end
                            end else begin
                                p_next     = head_reg[job.cls][PAGE_W-1:0];
                                state_next = S_META_RD;
                            end
                        end
                        OP_FREE: begin
                            p_next     = job.page;
                            state_next = S_META_RD;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_META_RD: begin
                meta_raddr = p_reg;
                state_next = S_META_LD;
            end
            S_META_LD: begin
                pm_next = rd_meta;
                if (op_reg == OP_ALLOC) begin
                    w_next     = '0;
                    state_next = S_SCAN_RD;
                end else if (rd_meta.cls >= 4'(CLASS_COUNT)) begin
                    status_next = ST_BAD_FREE;
                    state_next  = S_DONE;
                end else if (rel_reg < CLASS_TAB[rd_meta.cls].hdr) begin
                    status_next = ST_BAD_FREE;
                    state_next  = S_DONE;
                end else begin
                    cls_next   = rd_meta.cls;
                    dvd_next   = rel_reg - CLASS_TAB[rd_meta.cls].hdr;
                    rem_next   = '0;
                    quo_next   = '0;
                    dcnt_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_SCAN_RD: begin
                slot_raddr = {p_reg, w_reg};
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (slot_rdata != 32'hFFFF_FFFF &&
                    {1'b0, w_reg, zpos} < ci.elems) begin
                    idx_next      = {w_reg, zpos};
                    slot_we       = 1'b1;
                    slot_waddr    = {p_reg, w_reg};
                    slot_wdata    = slot_rdata | (32'd1 << zpos);
                    pm_next.count = pm_reg.count + 8'd1;
                    state_next    = S_ALLOC_CNT;
                end else if (4'(w_reg) + 4'd1 >= ci.nwords) begin
                    status_next = ST_NO_PAGE;
                    state_next  = S_META_WR;
                end else begin
                    w_next     = w_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_ALLOC_CNT: begin
                if ({1'b0, pm_reg.count} >= ci.elems) state_next = S_UNLINK;
                else state_next = S_META_WR;
            end
            S_DIV: begin
                // Restoring division, one quotient bit per cycle.
                if (r2 >= ci.limit) begin
                    rem_next = r2 - ci.limit;
                    quo_next = {quo_reg[10:0], 1'b1};
                end else begin
                    rem_next = r2;
                    quo_next = {quo_reg[10:0], 1'b0};
                end
                dvd_next  = {dvd_reg[10:0], 1'b0};
                dcnt_next = dcnt_reg + 4'd1;
                if (dcnt_reg == 4'd11) state_next = S_FREE_RD;
            end
            S_FREE_RD: begin
                if (rem_reg != 13'd0 || quo_reg >= 12'(ci.elems)) begin
                    status_next = ST_BAD_FREE;
                    cls_next    = '0;
                    state_next  = S_DONE;
                end else begin
                    idx_next   = quo_reg[IDX_W-1:0];
                    w_next     = quo_reg[IDX_W-1:5];
                    slot_raddr = {p_reg, quo_reg[IDX_W-1:5]};
                    state_next = S_FREE_CHK;
                end
            end
            S_FREE_CHK: begin
                if (!slot_rdata[idx_reg[4:0]]) begin
                    status_next = ST_BAD_FREE;
                    cls_next    = '0;
                    state_next  = S_DONE;
                end else begin
                    slot_we    = 1'b1;
                    slot_waddr = {p_reg, w_reg};
                    slot_wdata = slot_rdata & ~(32'd1 << idx_reg[4:0]);
                    if ({1'b0, pm_reg.count} >= ci.elems) state_next = S_LINK;
                    else state_next = S_FREE_CNT;
                end
            end
            S_LINK: begin
                pm_next.next       = head_reg[cls_reg];
                pm_next.prev       = NULL_LINK;
                head_next[cls_reg] = {1'b0, p_reg};
                if (head_reg[cls_reg] != NULL_LINK) begin
                    x_next     = head_reg[cls_reg][PAGE_W-1:0];
                    xf_next    = FLD_PREV;
                    xv_next    = {1'b0, p_reg};
                    ret_next   = S_FREE_CNT;
                    state_next = S_RMW_RD;
                end else begin
                    state_next = S_FREE_CNT;
                end
            end
            S_FREE_CNT: begin
                if (pm_reg.count > 8'd1) begin
                    pm_next.count = pm_reg.count - 8'd1;
                    state_next    = S_META_WR;
                end else begin
                    pm_next.count = 8'd0;
                    release_next  = 1'b1;
                    state_next    = S_UNLINK;
                end
            end
            S_UNLINK: begin
                if (pm_reg.prev != NULL_LINK) begin
                    x_next     = pm_reg.prev[PAGE_W-1:0];
                    xf_next    = FLD_NEXT;
                    xv_next    = pm_reg.next;
                    ret_next   = S_UNLINK2;
                    state_next = S_RMW_RD;
                end else begin
                    head_next[cls_reg] = pm_reg.next;
                    state_next         = S_UNLINK2;
                end
            end
            S_UNLINK2: begin
                if (pm_reg.next != NULL_LINK) begin
                    x_next     = pm_reg.next[PAGE_W-1:0];
                    xf_next    = FLD_PREV;
                    xv_next    = pm_reg.prev;
                    ret_next   = S_UNLINK3;
                    state_next = S_RMW_RD;
                end else begin
                    state_next = S_UNLINK3;
                end
            end
            S_UNLINK3: begin
                pm_next.next = NULL_LINK;
                pm_next.prev = NULL_LINK;
                if (release_reg) begin
                    pm_next.cls       = UNOWNED;
                    owned_next[p_reg] = 1'b0;
                end
                state_next = S_META_WR;
            end
            S_RMW_RD: begin
                meta_raddr = x_reg;
                state_next = S_RMW_WR;
            end
            S_RMW_WR: begin
                meta_we           = 1'b1;
                meta_waddr        = x_reg;
                meta_wdata        = mod_meta;
                valid_next[x_reg] = 1'b1;
                state_next        = ret_reg;
            end
            S_META_WR: begin
                meta_we           = 1'b1;
                meta_waddr        = p_reg;
                meta_wdata        = pm_reg;
                valid_next[p_reg] = 1'b1;
                if (op_reg == OP_ALLOC && status_reg == ST_OK) state_next = S_MUL;
                else state_next = S_DONE;
            end
            S_MUL: begin
                prod_next  = idx_reg * ci.limit[11:0];
                part_next  = base_address + 32'({p_reg, 12'd0}) + 32'(ci.hdr);
                state_next = S_ADDR;
            end
            S_ADDR: begin
                addr_next  = part_reg + 32'(prod_reg);
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.slot_address = addr_reg;
                    m_data_next.status       = status_reg;
                    m_data_next.size_class   = cls_reg;
                    state_next               = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            owned_reg   <= '0;
            valid_reg   <= '0;
            for (int i = 0; i < MAX_CLASSES; i++) head_reg[i] <= NULL_LINK;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            owned_reg   <= owned_next;
            valid_reg   <= valid_next;
            head_reg    <= head_next;
        end
        ret_reg     <= ret_next;
        op_reg      <= op_next;
        status_reg  <= status_next;
        cls_reg     <= cls_next;
        p_reg       <= p_next;
        rel_reg     <= rel_next;
        pm_reg      <= pm_next;
        w_reg       <= w_next;
        idx_reg     <= idx_next;
        x_reg       <= x_next;
        xf_reg      <= xf_next;
        xv_reg      <= xv_next;
        release_reg <= release_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dcnt_reg    <= dcnt_next;
        prod_reg    <= prod_next;
        part_reg    <= part_next;
        addr_reg    <= addr_next;
        m_data_reg  <= m_data_next;
        rvalid_reg  <= valid_reg[meta_raddr];
    end
endmodule

// ----- src/slab_bitmap_allocator.sv -----
// An allocate reads the page metadata, scans the bitmap words for a free slot and computes
// its address; a fresh page skips the metadata read, and a page that fills leaves its list.
// A free checks the address in the bit-serial divider and clears the slot bit; a full page
// is relinked, an empty one released. A request rejected at the front passes to the result.
// The back end works on one request at a time; the front end queues up to two more.
// After reset the slot bitmap memory, all 512 words, is cleared with s_ready low.
// ---------------------------------------------------------------------------
// slab_bitmap_allocator
// Slab allocator over a page pool with size classes and per-page slot bitmaps.
// ---------------------------------------------------------------------------
module slab_bitmap_allocator import sba_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  req_t        s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output rsp_t        m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [6:0]  pool_reg;
    logic [31:0] base_reg;
    logic        init_done;
    logic        job_valid;
    logic        job_ready;
    job_t        job;
    logic [1:0]  reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = {1'b0, paddr[2]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_reg <= 7'd64;
            base_reg <= 32'd65536;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_sel)
                REG_POOL: pool_reg <= pwdata[6:0];
                REG_BASE: base_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_POOL: prdata = {25'd0, pool_reg};
            REG_BASE: prdata = base_reg;
            default:  prdata = '0;
        endcase
    end

    sba_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .pool_pages(pool_reg), .base_address(base_reg), .init_done(init_done),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    sba_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .pool_pages(pool_reg), .base_address(base_reg), .init_done(init_done),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule

// ----- src/sba_checker.sv -----
// ---------------------------------------------------------------------------
// sba_checker
// Port-level checks on the result channel of the slab bitmap allocator.
// ---------------------------------------------------------------------------
module sba_checker import sba_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input rsp_t        m_data
);
    // A stalled result keeps its transaction.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    // Only a successful allocate carries an address.
    a_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.slot_address == 32'd0)
        else $error("failed request returned an address");

    // Rejected requests report class zero.
    a_cls: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_TOO_LARGE || m_data.status == ST_BAD_FREE)
        |-> m_data.size_class == 4'd0)
        else $error("rejected request reported a class");

    // Nothing is accepted or returned right after reset, while the bitmaps clear.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("activity right after reset");
endmodule

bind slab_bitmap_allocator sba_checker u_sba_checker (.*);

// ----- verif/tb_slab_bitmap_allocator.sv -----
// ---------------------------------------------------------------------------
// tb_slab_bitmap_allocator
// Self-checking bench for the slab bitmap allocator. A directed table is
// followed by random allocate/free traffic over several pool settings. Every
// response is checked, against the typed row or an in-bench model of the page pool.
// ---------------------------------------------------------------------------
module tb_slab_bitmap_allocator;
    import sba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PER_PHASE    = 340;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    req_t        s_data;
    logic        m_valid;
    logic        m_ready;
    rsp_t        m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    slab_bitmap_allocator i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Size class table and pool state of the model.
    int          lim_tab [MAX_CLASSES];
    int          elem_tab[MAX_CLASSES];
    int          hdr_tab [MAX_CLASSES];
    int          n_classes;
    logic [6:0]  cfg_pool;
    logic [31:0] cfg_base;
    logic [3:0]  pg_cls [PAGE_COUNT];
    int          pg_cnt [PAGE_COUNT];
    bit          pg_slot[PAGE_COUNT][256];
    int          pg_nxt [PAGE_COUNT];
    int          pg_prv [PAGE_COUNT];
    int          cls_head[MAX_CLASSES];

    rsp_t        expected_rsp_q[$];
    logic [31:0] live_addr_q[$];
    logic [31:0] freed_addr_q[$];
    int          mismatches;
    int          rsp_seen;
    int          n_alloc_ok, n_too_large, n_no_page, n_free_ok, n_bad_free;
    bit          no_idle;
    int          hold_len;
    int          cycles;

    function automatic int header_size(int slots);
        int raw;
        raw = HEADER_FIXED_BYTES + 4 * ((slots + 31) / 32);
        return ((raw + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    function automatic void build_size_table();
        int cap;
        int lim;
        int prev;
        int e;
        cap       = PAGE_BYTES - header_size(1);
        prev      = 0;
        n_classes = 0;
        for (int c = 0; c < MAX_CLASSES; c++) begin
            if (c == 0) begin
                lim = BASE_CLASS_BYTES;
            end else begin
                lim = (3 * prev) / 2;
                lim = ((lim + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
                if (lim > cap) begin
                    lim = cap;
                    if (lim == prev) break;
                end
            end
            e = cap / lim;
            while (e > 0 && e * lim + header_size(e) > PAGE_BYTES) e--;
            if (e > WORDS_PER_PAGE * 32) e = WORDS_PER_PAGE * 32;
            if (e < 1) break;
            lim_tab[c]  = lim;
            elem_tab[c] = e;
            hdr_tab[c]  = header_size(e);
            prev        = lim;
            n_classes   = c + 1;
        end
    endfunction

    function automatic void pool_reset();
        for (int p = 0; p < PAGE_COUNT; p++) begin
            pg_cls[p] = UNOWNED;
            pg_cnt[p] = 0;
            pg_nxt[p] = PAGE_COUNT;
            pg_prv[p] = PAGE_COUNT;
            for (int s = 0; s < 256; s++) pg_slot[p][s] = 1'b0;
        end
        for (int c = 0; c < MAX_CLASSES; c++) cls_head[c] = PAGE_COUNT;
        cfg_pool = 7'd64;
        cfg_base = 32'd65536;
    endfunction

    function automatic void push_front_page(int p, int c);
        pg_nxt[p] = cls_head[c];
        pg_prv[p] = PAGE_COUNT;
        if (cls_head[c] < PAGE_COUNT) pg_prv[cls_head[c]] = p;
        cls_head[c] = p;
    endfunction

    function automatic void drop_page(int p, int c);
        if (pg_prv[p] < PAGE_COUNT) pg_nxt[pg_prv[p]] = pg_nxt[p];
        else cls_head[c] = pg_nxt[p];
        if (pg_nxt[p] < PAGE_COUNT) pg_prv[pg_nxt[p]] = pg_prv[p];
        pg_nxt[p] = PAGE_COUNT;
        pg_prv[p] = PAGE_COUNT;
    endfunction

    // Works out the response to one request and advances the pool state.
    function automatic rsp_t slab_predict(req_t r);
        rsp_t        o;
        int          c;
        int          p;
        int          idx;
        int          npages;
        logic [31:0] off;
        int          rel;
        o = '{slot_address: '0, status: ST_OK, size_class: '0};
        npages = (cfg_pool > PAGE_COUNT) ? PAGE_COUNT : int'(cfg_pool);
        if (r.command == CMD_ALLOC) begin
            if (int'(r.request_size) > lim_tab[n_classes-1]) begin
                o.status = ST_TOO_LARGE;
                return o;
            end
            c = 0;
            while (c + 1 < n_classes && lim_tab[c] < int'(r.request_size)) c++;
            o.size_class = 4'(c);
            if (cls_head[c] >= PAGE_COUNT) begin
                p = 0;
                while (p < npages && pg_cls[p] != UNOWNED) p++;
                if (p >= npages) begin
                    o.status = ST_NO_PAGE;
                    return o;
                end
                pg_cls[p] = 4'(c);
                pg_cnt[p] = 0;
                for (int s = 0; s < 256; s++) pg_slot[p][s] = 1'b0;
                push_front_page(p, c);
            end
            p   = cls_head[c];
            idx = 0;
            while (idx < elem_tab[c] && pg_slot[p][idx]) idx++;
            if (idx >= elem_tab[c]) begin
                o.status = ST_NO_PAGE;
                return o;
            end
            pg_slot[p][idx] = 1'b1;
            pg_cnt[p]++;
            if (pg_cnt[p] >= elem_tab[c]) drop_page(p, c);
            o.slot_address = cfg_base + 32'(p * PAGE_BYTES) + 32'(hdr_tab[c])
                           + 32'(idx * lim_tab[c]);
        end else begin
            if (r.free_address == 0) return o;
            o.status = ST_BAD_FREE;
            if (r.free_address < cfg_base) return o;
            off = r.free_address - cfg_base;
            if (off / PAGE_BYTES >= npages) return o;
            p = int'(off / PAGE_BYTES);
            c = int'(pg_cls[p]);
            if (c >= n_classes) return o;
            rel = int'(off % PAGE_BYTES);
            if (rel < hdr_tab[c]) return o;
            rel -= hdr_tab[c];
            if (rel % lim_tab[c] != 0) return o;
            idx = rel / lim_tab[c];
            if (idx >= elem_tab[c] || !pg_slot[p][idx]) return o;
            o.status     = ST_OK;
            o.size_class = 4'(c);
            pg_slot[p][idx] = 1'b0;
            if (pg_cnt[p] >= elem_tab[c]) push_front_page(p, c);
            if (pg_cnt[p] > 0) pg_cnt[p]--;
            if (pg_cnt[p] == 0) begin
                drop_page(p, c);
                pg_cls[p] = UNOWNED;
            end
        end
        return o;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses pending", cycles,
                     expected_rsp_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Response side: random stalls, plus a long hold-off when asked for.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_len > 0) begin
            m_ready <= 1'b0;
            hold_len = hold_len - 1;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            rsp_seen++;
            if (expected_rsp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response %p", m_data);
            end else begin
                want = expected_rsp_q.pop_front();
                if (m_data.slot_address !== want.slot_address
                        || m_data.status !== want.status
                        || m_data.size_class !== want.size_class) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("response %0d: expected addr %h status %s class %0d,",
                                 rsp_seen, want.slot_address, want.status.name(),
                                 want.size_class);
                        $display("    got addr %h status %s class %0d",
                                 m_data.slot_address, m_data.status.name(),
                                 m_data.size_class);
                    end
                end
            end
        end
    end

    task automatic send_req(input req_t r, input bit typed, input rsp_t typed_rsp);
        int   gap;
        rsp_t got;
        gap = 0;
        if (!no_idle) while ($urandom_range(99) < 9) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        got = slab_predict(r);
        expected_rsp_q.push_back(typed ? typed_rsp : got);
        if (r.command == CMD_ALLOC) begin
            case (got.status)
                ST_OK:        begin n_alloc_ok++; live_addr_q.push_back(got.slot_address); end
                ST_TOO_LARGE: n_too_large++;
                default:      n_no_page++;
            endcase
        end else if (got.status == ST_OK) begin
            n_free_ok++;
        end else begin
            n_bad_free++;
        end
        @(negedge aclk);
    endtask

    task automatic send_alloc(input int size);
        req_t r;
        r = '{command: CMD_ALLOC, request_size: 13'(size), free_address: $urandom};
        send_req(r, 1'b0, '0);
    endtask

    task automatic send_free(input logic [31:0] a);
        req_t r;
        r = '{command: CMD_FREE, request_size: 13'($urandom), free_address: a};
        send_req(r, 1'b0, '0);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(negedge aclk);
    endtask

    task automatic reg_write(input logic [1:0] reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 1'b0} << 1;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_POOL) cfg_pool = value[6:0];
        else cfg_base = value;
    endtask

    task automatic free_all_live();
        while (live_addr_q.size() != 0) begin
            freed_addr_q.push_back(live_addr_q[0]);
            send_free(live_addr_q.pop_front());
        end
    endtask

    task automatic random_traffic(input int n_items, input int pressure);
        int          k;
        int          pick;
        logic [31:0] a;
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2 && pressure == 1) begin
                // Receiver stalls long enough for the input side to back up.
                s_valid <= 1'b0;
                @(posedge aclk);
                hold_len = 400;
                @(negedge aclk);
            end
            if (i == n_items / 2 && pressure == 2) wait_drained();
            no_idle = (i >= n_items / 4 && i < n_items / 4 + 80);
            k = $urandom_range(99);
            if (k < 52) begin
                pick = $urandom_range(99);
                if (pick < 75) send_alloc($urandom_range(300));
                else if (pick < 96) send_alloc($urandom_range(4096));
                else send_alloc($urandom_range(8191));
            end else if (k < 92 && live_addr_q.size() != 0) begin
                pick = $urandom_range(live_addr_q.size() - 1);
                a = live_addr_q[pick];
                live_addr_q.delete(pick);
                freed_addr_q.push_back(a);
                if (freed_addr_q.size() > 16) void'(freed_addr_q.pop_front());
                send_free(a);
            end else begin
                pick = $urandom_range(4);
                case (pick)
                    0: a = $urandom;
                    1: a = (freed_addr_q.size() != 0) ? freed_addr_q[0] : 32'd0;
                    2: a = (live_addr_q.size() != 0) ? live_addr_q[0] + 8 : cfg_base;
                    3: a = cfg_base + 32'($urandom_range(70) * PAGE_BYTES)
                           + 32'($urandom_range(63));
                    default: a = 32'd0;
                endcase
                send_free(a);
            end
        end
        no_idle = 1'b0;
    endtask

    typedef struct {
        req_t stim;
        bit   typed;
        rsp_t rsp;
    } dir_row_t;

    dir_row_t    dir_tab[$];
    logic [31:0] pool_set[5];
    logic [31:0] base_set[5];

    function automatic dir_row_t row(input logic cmd, input int size, input logic [31:0] a,
                                     input bit typed, input logic [31:0] ra,
                                     input status_t st, input int cls);
        dir_row_t d;
        d.stim  = '{command: cmd, request_size: 13'(size), free_address: a};
        d.typed = typed;
        d.rsp   = '{slot_address: ra, status: st, size_class: 4'(cls)};
        return d;
    endfunction

    initial begin
        s_valid    = 1'b0;
        s_data     = '0;
        m_ready    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        aresetn    = 1'b0;
        no_idle    = 1'b0;
        hold_len   = 0;
        cycles     = 0;
        mismatches = 0;
        rsp_seen   = 0;
        build_size_table();
        pool_reset();

        // Page 0 at the reset base: class 0 has a 64-byte header.
        dir_tab.push_back(row(CMD_ALLOC, 0, 0, 1, 32'd65600, ST_OK, 0));
        dir_tab.push_back(row(CMD_ALLOC, 4096, 0, 1, 0, ST_TOO_LARGE, 0));
        dir_tab.push_back(row(CMD_ALLOC, 8191, 0, 1, 0, ST_TOO_LARGE, 0));
        dir_tab.push_back(row(CMD_ALLOC, 4049, 0, 1, 0, ST_TOO_LARGE, 0));
        dir_tab.push_back(row(CMD_FREE, 0, 0, 1, 0, ST_OK, 0));
        dir_tab.push_back(row(CMD_FREE, 0, 32'd100, 1, 0, ST_BAD_FREE, 0));
        dir_tab.push_back(row(CMD_FREE, 0, 32'd65536, 1, 0, ST_BAD_FREE, 0));
        dir_tab.push_back(row(CMD_FREE, 0, 32'd65608, 1, 0, ST_BAD_FREE, 0));
        dir_tab.push_back(row(CMD_FREE, 0, 32'd65616, 1, 0, ST_BAD_FREE, 0));
        dir_tab.push_back(row(CMD_FREE, 0, 32'd65600, 1, 0, ST_OK, 0));
        dir_tab.push_back(row(CMD_FREE, 0, 32'd65600, 1, 0, ST_BAD_FREE, 0));
        dir_tab.push_back(row(CMD_FREE, 0, 32'hFFFF_FFFF, 1, 0, ST_BAD_FREE, 0));
        dir_tab.push_back(row(CMD_FREE, 0, 32'd65536 + 64 * 4096 + 64, 1, 0,
                              ST_BAD_FREE, 0));
        dir_tab.push_back(row(CMD_ALLOC, 4048, 0, 0, 0, ST_OK, 0));
        dir_tab.push_back(row(CMD_ALLOC, 4048, 0, 0, 0, ST_OK, 0));
        dir_tab.push_back(row(CMD_ALLOC, 1, 0, 0, 0, ST_OK, 0));
        dir_tab.push_back(row(CMD_ALLOC, 16, 0, 0, 0, ST_OK, 0));
        dir_tab.push_back(row(CMD_ALLOC, 17, 0, 0, 0, ST_OK, 0));
        dir_tab.push_back(row(CMD_ALLOC, 1000, 0, 0, 0, ST_OK, 0));
        dir_tab.push_back(row(CMD_ALLOC, 2241, 0, 0, 0, ST_OK, 0));
        dir_tab.push_back(row(CMD_FREE, 8191, 32'd65536 + 63 * 4096 + 64, 1, 0,
                              ST_BAD_FREE, 0));

        pool_set = '{32'd64, 32'd3, 32'd127, 32'd1, 32'd64};
        base_set = '{32'd65536, 32'd4096, 32'hF000_0000, 32'h1000_0000,
                     32'($urandom_range(1, 32'hF_0000)) << 12};

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_tab[i]) send_req(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].rsp);
        // Slots still live after the table are released before the random part.
        free_all_live();

        for (int ph = 0; ph < 5; ph++) begin
            if (ph != 0) begin
                wait_drained();
                repeat (DRAIN_CYCLES) @(negedge aclk);
                reg_write(REG_POOL, pool_set[ph]);
                reg_write(REG_BASE, base_set[ph]);
            end
            // Fill a full class 0 page so that a page leaves and rejoins its list.
            if (ph == 4) begin
                for (int j = 0; j < 260; j++) send_alloc(0);
            end
            random_traffic(PER_PHASE, (ph == 1) ? 1 : (ph == 2) ? 2 : 0);
            free_all_live();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("covered %0d responses: %0d allocations, %0d too large, %0d pool empty,",
                 rsp_seen, n_alloc_ok, n_too_large, n_no_page);
        $display("    %0d good frees, %0d rejected frees over five pool settings",
                 n_free_ok, n_bad_free);
        if (mismatches == 0 && expected_rsp_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/sba_pkg.sv
src/sba_ram.sv
src/sba_front.sv
src/sba_back.sv
src/slab_bitmap_allocator.sv
src/sba_checker.sv
verif/tb_slab_bitmap_allocator.sv
